// ----- rtl/tdpc_pkg.sv -----
// Shared types and constants for the two-dimensional parity checker.
// Used by tdpc_lane, tdpc_merge and two_dim_parity_checker_core.
package tdpc_pkg;

  // Fixed field widths of the row transaction and the result.
  localparam int PIX_W      = 32;
  localparam int LANE_W     = 8;
  localparam int N_LANES    = PIX_W / LANE_W;
  localparam int LANE_IDX_W = $clog2(LANE_W);
  localparam int IDX_W      = 5;
  localparam int RIDX_W     = 6;
  localparam int CNT_W      = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CORRECT  = 2'd0,
    ST_REPAIR   = 2'd1,
    ST_UNREPAIR = 2'd2
  } status_t;

  // What one lane finds in its slice of the operand word.
  typedef struct packed {
    logic                  par;
    logic                  found;
    logic [LANE_IDX_W-1:0] first;
    logic [CNT_W-1:0]      cnt;
  } lane_res_t;

  // What the merging stage makes of all lanes.
  typedef struct packed {
    logic             par;
    logic             found;
    logic [IDX_W-1:0] first;
    logic [CNT_W-1:0] cnt;
  } col_res_t;

endpackage

// ----- rtl/tdpc_lane.sv -----
// One lane of the checker: parity, first set bit and saturated set-bit
// count over an LANE_W-bit slice. Depends on tdpc_pkg.
module tdpc_lane (
  input  logic [tdpc_pkg::LANE_W-1:0] slice_i,
  output tdpc_pkg::lane_res_t         res_o
);
  import tdpc_pkg::*;

  // Scan the slice from the low bit upward.
  always_comb begin
    res_o = '0;
    for (int k = 0; k < LANE_W; k++) begin
      if (slice_i[k]) begin
        res_o.par = ~res_o.par;
        if (!res_o.found) begin
          res_o.found = 1'b1;
          res_o.first = LANE_IDX_W'(k);
        end
        if (res_o.cnt < CNT_W'(2)) begin
          res_o.cnt = res_o.cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/tdpc_merge.sv -----
// Merging stage: combines the lane results into whole-row parity, the
// lowest set column and a count saturated at two. Depends on tdpc_pkg.
module tdpc_merge (
  input  tdpc_pkg::lane_res_t lanes_i [tdpc_pkg::N_LANES],
  output tdpc_pkg::col_res_t  res_o
);
  import tdpc_pkg::*;

  localparam int SUM_W = $clog2(2 * N_LANES + 1);

  logic [SUM_W-1:0] sum;

  // Lowest lane with a set bit gives the first column.
  always_comb begin
    res_o = '0;
    sum   = '0;
    for (int l = 0; l < N_LANES; l++) begin
      res_o.par = res_o.par ^ lanes_i[l].par;
      sum       = sum + SUM_W'(lanes_i[l].cnt);
      if (lanes_i[l].found && !res_o.found) begin
        res_o.found = 1'b1;
        res_o.first = IDX_W'(l * LANE_W) + IDX_W'(lanes_i[l].first);
      end
    end
    res_o.cnt = (sum >= SUM_W'(2)) ? CNT_W'(2) : CNT_W'(sum);
  end

endmodule

// ----- rtl/two_dim_parity_checker_core.sv -----
// Two-dimensional parity checker, top level. Depends on tdpc_pkg, tdpc_lane, tdpc_merge.
// Result path: a parity-row transaction passes the lane stage register, then the
// output register, before its result shows; data rows give no result.
// Throughput: one row transaction per cycle while in_ready is high; the lane stage
// holds a parity row only while a previous result still waits at the output register.
// Reset: synchronous active-low rst_n clears the pipeline valids, the column
// accumulator, the row counter, the bad-row tally and the first bad-row index.
module two_dim_parity_checker_core #(
  parameter int COLS = 32,
  parameter int ROWS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tdpc_pkg::PIX_W-1:0] in_pixel_row,
  input  logic                       in_row_parity,
  input  logic                       in_is_parity_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [tdpc_pkg::IDX_W-1:0] out_bad_row,
  output logic                       out_bad_row_found,
  output logic [tdpc_pkg::IDX_W-1:0] out_bad_col,
  output logic                       out_bad_col_found,
  output logic [tdpc_pkg::CNT_W-1:0] out_row_error_count,
  output logic [tdpc_pkg::CNT_W-1:0] out_col_error_count
);
  import tdpc_pkg::*;

  localparam int RCMP_W = RIDX_W + 1;

  // Column mask: only columns below COLS carry pixels.
  logic [PIX_W-1:0] col_mask;
  always_comb begin
    for (int k = 0; k < PIX_W; k++) begin
      col_mask[k] = (k < COLS);
    end
  end

  // Front-end state updated at acceptance.
  logic [PIX_W-1:0]  acc_r, acc_nxt;
  logic [RIDX_W-1:0] row_idx_r, row_idx_nxt;

  // Lane stage registers.
  logic              a_vld_r;
  logic              a_close_r;
  logic              a_counted_r;
  logic              a_rpar_r;
  logic [IDX_W-1:0]  a_idx_r;
  lane_res_t         a_lane_r [N_LANES];

  // Back-end state and output register.
  logic [CNT_W-1:0]  tally_r, tally_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic              out_vld_r;
  status_t           status_r;
  logic [IDX_W-1:0]  bad_row_r;
  logic              bad_row_found_r;
  logic [IDX_W-1:0]  bad_col_r;
  logic              bad_col_found_r;
  logic [CNT_W-1:0]  row_cnt_r;
  logic [CNT_W-1:0]  col_cnt_r;

  logic              in_acc;
  logic              a_adv;
  logic              counted;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  operand;
  lane_res_t         lane_res [N_LANES];
  col_res_t          merged;
  status_t           status_nxt;

  // Handshake: the lane stage drains unless a parity row meets a full output.
  assign a_adv    = a_vld_r && (!a_close_r || !out_vld_r || out_ready);
  assign in_ready = !a_vld_r || a_adv;
  assign in_acc   = in_valid && in_ready;

  // Lane operand is the row itself, or the column syndrome on a parity row.
  assign pix     = in_pixel_row & col_mask;
  assign operand = in_is_parity_row ? ((acc_r ^ pix) & col_mask) : pix;
  assign counted = ({1'b0, row_idx_r} < RCMP_W'(ROWS));

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    tdpc_lane u_lane (
      .slice_i (operand[l*LANE_W +: LANE_W]),
      .res_o   (lane_res[l])
    );
  end

  // Accumulator and row counter advance on each counted data row and clear on a parity row.
  always_comb begin
    acc_nxt     = acc_r;
    row_idx_nxt = row_idx_r;
    if (in_acc) begin
      if (in_is_parity_row) begin
        acc_nxt     = '0;
        row_idx_nxt = '0;
      end else if (counted) begin
        acc_nxt     = acc_r ^ pix;
        row_idx_nxt = row_idx_r + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      row_idx_r <= '0;
      a_vld_r   <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      row_idx_r <= row_idx_nxt;
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
    end
  end

  // Lane stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_close_r   <= in_is_parity_row;
      a_counted_r <= counted;
      a_rpar_r    <= in_row_parity;
      a_idx_r     <= row_idx_r[IDX_W-1:0];
      a_lane_r    <= lane_res;
    end
  end

  tdpc_merge u_merge (
    .lanes_i (a_lane_r),
    .res_o   (merged)
  );

  // Bad-row tally: record the first bad row and saturate the count at two; a parity row clears both.
  always_comb begin
    tally_nxt = tally_r;
    first_nxt = first_r;
    if (a_adv) begin
      if (a_close_r) begin
        tally_nxt = '0;
        first_nxt = '0;
      end else if (a_counted_r && (merged.par != a_rpar_r)) begin
        if (tally_r == '0) begin
          first_nxt = a_idx_r;
        end
        if (tally_r < CNT_W'(2)) begin
          tally_nxt = tally_r + CNT_W'(1);
        end
      end
    end
  end

  // Status classification from row tally and column count.
  always_comb begin
    if ((tally_r > CNT_W'(1)) || (merged.cnt > CNT_W'(1))) begin
      status_nxt = ST_UNREPAIR;
    end else if ((tally_r == '0) && (merged.cnt == '0)) begin
      status_nxt = ST_CORRECT;
    end else begin
      status_nxt = ST_REPAIR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r   <= '0;
      first_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      tally_r <= tally_nxt;
      first_r <= first_nxt;
      if (a_adv && a_close_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result register loads when a parity row leaves the lane stage.
  always_ff @(posedge clk) begin
    if (a_adv && a_close_r) begin
      status_r        <= status_nxt;
      bad_row_r       <= (tally_r != '0) ? first_r : '0;
      bad_row_found_r <= (tally_r != '0);
      bad_col_r       <= merged.first;
      bad_col_found_r <= merged.found;
      row_cnt_r       <= tally_r;
      col_cnt_r       <= merged.cnt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_status          = status_r;
  assign out_bad_row         = bad_row_r;
  assign out_bad_row_found   = bad_row_found_r;
  assign out_bad_col         = bad_col_r;
  assign out_bad_col_found   = bad_col_found_r;
  assign out_row_error_count = row_cnt_r;
  assign out_col_error_count = col_cnt_r;

  // The input only stalls behind a parity row facing an occupied output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_vld_r && a_close_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked parity row");

  // A correct status means no row and no column was flagged.
  a_correct_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_CORRECT)) |->
      (!out_bad_row_found && !out_bad_col_found))
    else $error("correct status with a flagged row or column");

  // Found flags agree with the saturated counts.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_bad_row_found == (out_row_error_count != '0)) &&
                   (out_bad_col_found == (out_col_error_count != '0))))
    else $error("found flag disagrees with error count");

  // A parity row leaving the lane stage always produces a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_close_r) |=> out_valid)
    else $error("parity row produced no result");

endmodule
